### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion helpers shared by the deframer RTL
// Every check is clocked on i_clk and held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check
`define FR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen
`define FR_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

### hw/rtl/fr_pkg.sv
// ---------------------------------------------------------------------------
// fr_pkg
// Types and constants shared by the fragment reassembler modules.
// ---------------------------------------------------------------------------
package fr_pkg;

    // Message buffer size in bytes and offset width (offset saturates at size)
    localparam int          OFF_W     = 9;
    localparam logic [8:0]  BUF_BYTES = 9'd256;

    // Header byte layout
    localparam logic [7:0]  HDR_LEN_MASK  = 8'h3F;
    localparam logic [7:0]  HDR_LAST_BIT  = 8'h80;
    localparam logic [7:0]  HDR_FIRST_BIT = 8'h40;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Input word
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_first;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_addr;
        logic [7:0] store_data;
        logic       message_done;
        logic [8:0] message_length;
        logic       partial_dropped;
        logic       fragment_rejected;
        logic       overflow;
    } t_out_word;

    // Classified byte, as queued for the back end
    typedef struct packed {
        logic       is_header;
        logic       hdr_first;
        logic       hdr_last;
        logic [5:0] hdr_len;
        logic       len_zero;
        logic [7:0] data;
    } t_entry;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### hw/rtl/fragment_reassembler.sv
// ---------------------------------------------------------------------------
// fragment_reassembler
// Byte-stream deframer: rebuilds messages from header-led packets and emits
// one result word (buffer write and status flags) for every input byte.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_data  (t_in_word)
//   output   out        o_valid / i_stall   o_data  (t_out_word)
//
// One byte per clock sustained while the output is not stalled; a taken byte is
// written into the queue, then the back end steps its state and registers its
// result. The back-end step (offset, payload count, last/discard flags) is the
// per-byte loop; it handles one queued byte each cycle the output is not stalled.
// Reset (i_rst_n low, synchronous) clears the queue, the message state and
// the result valid.
// An output stall holds the result; the four-word queue keeps taking input
// until full, then o_stall rises.
// ---------------------------------------------------------------------------
module fragment_reassembler import fr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    t_q_status q_status;
    t_entry    push_entry;
    t_entry    head_entry;
    logic      push;
    logic      pop;

    fr_front u_front (
        .i_valid    (i_valid),
        .i_data     (i_data),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    fr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    fr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule

### hw/rtl/fr_front.sv
// ---------------------------------------------------------------------------
// fr_front
// Takes input words and classifies each byte as header or payload,
// decoding the header fields before the byte enters the queue.
// ---------------------------------------------------------------------------
module fr_front import fr_pkg::*; (
    input  logic      i_valid,
    input  t_in_word  i_data,
    input  t_q_status i_q_status,
    output logic      o_stall,
    output logic      o_push,
    output t_entry    o_entry
);

    // Hold off the sender only while the queue has no room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Header decode
    always_comb begin
        o_entry           = '0;
        o_entry.is_header = i_data.packet_first;
        o_entry.hdr_first = |(i_data.rx_byte & HDR_FIRST_BIT);
        o_entry.hdr_last  = |(i_data.rx_byte & HDR_LAST_BIT);
        o_entry.hdr_len   = 6'(i_data.rx_byte & HDR_LEN_MASK);
        o_entry.len_zero  = ((i_data.rx_byte & HDR_LEN_MASK) == 8'h00);
        o_entry.data      = i_data.rx_byte;
    end

endmodule

### hw/rtl/fr_queue.sv
// ---------------------------------------------------------------------------
// fr_queue
// Short FIFO of classified bytes between the front and back ends.
// ---------------------------------------------------------------------------
module fr_queue import fr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_entry,
    output t_q_status o_status
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count,  n_count;
    logic              push, pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign push = i_push && !o_status.full;
    assign pop  = i_pop && !o_status.empty;
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = push ? Q_AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? Q_AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`include "assert_macros.svh"

    `FR_NEVER(a_q_count_range, r_count > Q_CW'(Q_DEPTH), "queue fill count beyond depth")
    `FR_ASSERT(a_q_ptr_gap, Q_AW'(r_wr_ptr - r_rd_ptr) == Q_AW'(r_count), "queue pointers disagree with count")

endmodule

### hw/rtl/fr_back.sv
// ---------------------------------------------------------------------------
// fr_back
// Reassembly state machine: applies each queued byte to the message
// offset and packet state and registers one result word per byte.
// ---------------------------------------------------------------------------
module fr_back import fr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_entry,
    input  t_q_status i_q_status,
    input  logic      i_stall,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_word o_data
);

    logic [OFF_W-1:0] r_offset, n_offset;
    logic [5:0]       r_left,   n_left;
    logic             r_last,   n_last;
    logic             r_disc,   n_disc;
    logic             r_out_valid;
    t_out_word        r_out, n_out;
    logic             load;

    // Take a new byte when the result register is free or being drained
    assign load    = !i_q_status.empty && (!r_out_valid || !i_stall);
    assign o_pop   = load;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Per-byte reassembly step
    always_comb begin
        n_offset = r_offset;
        n_left   = r_left;
        n_last   = r_last;
        n_disc   = r_disc;
        n_out    = '0;
        if (i_entry.is_header) begin
            // first header mid-message drops the partial message
            if (i_entry.hdr_first && (r_offset != '0)) begin
                n_out.partial_dropped = 1'b1;
                n_offset = '0;
            end
            if (!i_entry.hdr_first && (r_offset == '0)) begin
                // continuation with nothing open: throw the packet away
                n_out.fragment_rejected = 1'b1;
                n_disc = 1'b1;
                n_left = '0;
                n_last = 1'b0;
            end else begin
                n_disc = 1'b0;
                n_left = i_entry.hdr_len;
                n_last = i_entry.hdr_last;
                // empty last fragment completes on the header
                if (i_entry.len_zero && i_entry.hdr_last) begin
                    n_out.message_done   = 1'b1;
                    n_out.message_length = n_offset;
                    n_offset = '0;
                    n_last   = 1'b0;
                end
            end
        end else if (!r_disc && (r_left != '0)) begin
            if (r_offset < BUF_BYTES) begin
                n_out.store_valid = 1'b1;
                n_out.store_addr  = r_offset[7:0];
                n_out.store_data  = i_entry.data;
                n_offset = OFF_W'(r_offset + 1'b1);
            end else begin
                n_out.overflow = 1'b1;
                n_offset = BUF_BYTES;
            end
            n_left = 6'(r_left - 1'b1);
            if ((n_left == '0) && r_last) begin
                n_out.message_done   = 1'b1;
                n_out.message_length = n_offset;
                n_offset = '0;
                n_last   = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_disc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_offset <= n_offset;
                r_left   <= n_left;
                r_last   <= n_last;
                r_disc   <= n_disc;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

`include "assert_macros.svh"

    `FR_NEVER(a_offset_range, r_offset > BUF_BYTES, "write offset beyond buffer size")
    `FR_ASSERT(a_done_clears, (load && n_out.message_done) |=> (r_offset == '0), "offset not cleared after message end")
    `FR_NEVER(a_store_ovf, r_out_valid && r_out.store_valid && r_out.overflow, "store and overflow together")
    `FR_ASSERT(a_stall_hold, (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)), "stalled result changed")

endmodule

### test/tb_fragment_reassembler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fragment_reassembler
// Self-checking bench for the packet deframer. A local model tracks the
// message offset, payload count and last/discard flags, predicts one result
// word per input byte and the checker compares each result field by field.
// Traffic is directed corner cases, then random well-formed messages mixed
// with abandoned messages, stray continuations and noise, under several
// sender-idle / receiver-stall mixes, plus a long output hold-off and a
// buffer overflow message.
// ---------------------------------------------------------------------------
module tb_fragment_reassembler;
    import fr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_word  i_data  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_data;

    fragment_reassembler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deframer model state
    logic [8:0] asm_offset   = '0;
    logic [5:0] pkt_left     = '0;
    logic       pkt_is_last  = 1'b0;
    logic       pkt_discard  = 1'b0;

    t_out_word  pending_results[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    int n_sent      = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_done      = 0;
    int n_dropped   = 0;
    int n_rejected  = 0;
    int n_overflow  = 0;
    int n_in_stalls = 0;
    int idle_cycles = 0;

    // One deframer step: consume a byte, return the result word it causes
    function automatic t_out_word deframe_step(t_in_word w);
        t_out_word  r;
        logic [5:0] len;
        logic       hdr_last;
        logic       hdr_first;
        r         = '0;
        len       = 6'(w.rx_byte & HDR_LEN_MASK);
        hdr_last  = |(w.rx_byte & HDR_LAST_BIT);
        hdr_first = |(w.rx_byte & HDR_FIRST_BIT);
        if (w.packet_first) begin
            // first header restarts any message in progress
            if (hdr_first && asm_offset != 0) begin
                r.partial_dropped = 1'b1;
                asm_offset = '0;
            end
            if (!hdr_first && asm_offset == 0) begin
                r.fragment_rejected = 1'b1;
                pkt_discard = 1'b1;
                pkt_left    = '0;
                pkt_is_last = 1'b0;
            end else begin
                pkt_discard = 1'b0;
                pkt_left    = len;
                pkt_is_last = hdr_last;
                if (len == 0 && hdr_last) begin
                    r.message_done   = 1'b1;
                    r.message_length = asm_offset;
                    asm_offset  = '0;
                    pkt_is_last = 1'b0;
                end
            end
        end else if (!pkt_discard && pkt_left != 0) begin
            // payload byte: write or flag overflow, offset saturates
            if (asm_offset < BUF_BYTES) begin
                r.store_valid = 1'b1;
                r.store_addr  = asm_offset[7:0];
                r.store_data  = w.rx_byte;
                asm_offset    = asm_offset + 9'd1;
            end else begin
                r.overflow = 1'b1;
                asm_offset = BUF_BYTES;
            end
            pkt_left = pkt_left - 6'd1;
            if (pkt_left == 0 && pkt_is_last) begin
                r.message_done   = 1'b1;
                r.message_length = asm_offset;
                asm_offset  = '0;
                pkt_is_last = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_in_word hdr_word(bit first, bit last, int len);
        t_in_word w;
        w.rx_byte      = (first ? HDR_FIRST_BIT : 8'h00) | (last ? HDR_LAST_BIT : 8'h00)
                       | (8'(len) & HDR_LEN_MASK);
        w.packet_first = 1'b1;
        return w;
    endfunction

    function automatic t_in_word data_word(logic [7:0] b);
        t_in_word w;
        w.rx_byte      = b;
        w.packet_first = 1'b0;
        return w;
    endfunction

    // Mostly short payloads, with empty and maximum lengths mixed in
    function automatic int pick_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 0;
        else if (sel < 18)
            return 63;
        else if (sel < 30)
            return $urandom_range(0, 63);
        return $urandom_range(1, 10);
    endfunction

    // Offer one word, wait for it to be taken, queue its prediction
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(deframe_step(w));
        n_sent++;
    endtask

    // Header, random payload, then optional padding
    task automatic send_packet(bit first, bit last, int len);
        send_word(hdr_word(first, last, len));
        repeat (len) send_word(data_word(8'($urandom)));
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) send_word(data_word(8'($urandom)));
    endtask

    // Sender pauses until every predicted word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Corner cases: stray bytes, rejects, empty fragments, restarts
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_word(data_word(8'hFF));          // byte with no packet open
        send_word(hdr_word(0, 1, 3));         // continuation at offset zero
        send_word(data_word(8'h00));
        send_word(data_word(8'h55));
        send_word(data_word(8'hFF));
        send_word(hdr_word(1, 1, 0));         // empty single-fragment message
        send_word(hdr_word(1, 0, 0));         // empty first leaves offset zero
        send_word(hdr_word(0, 0, 2));         // ... so this is rejected
        send_word(data_word(8'h11));
        send_word(hdr_word(1, 0, 2));
        send_word(data_word(8'h00));
        send_word(data_word(8'hFF));
        send_word(data_word(8'hAA));          // padding
        send_word(hdr_word(1, 0, 1));         // first mid-message: drop
        send_word(data_word(8'h5A));
        send_word(hdr_word(0, 1, 0));         // empty last completes on header
        send_word(hdr_word(1, 1, 1));
        send_word(data_word(8'hC3));
        drain_results();
    endtask

    // Random traffic: mostly complete messages, some broken ones and noise
    task automatic test_random_traffic(int n_words, int idle_pct, int hold_pct);
        int stop;
        int sel;
        int nfrag;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        stop          = n_sent + n_words;
        while (n_sent < stop) begin
            sel   = $urandom_range(99);
            nfrag = $urandom_range(1, 4);
            if (sel < 75) begin
                for (int k = 0; k < nfrag; k++)
                    send_packet(k == 0, k == nfrag - 1, pick_len());
            end else if (sel < 87) begin
                // abandoned: never sends a last fragment
                for (int k = 0; k < nfrag; k++)
                    send_packet(k == 0, 1'b0, pick_len());
            end else if (sel < 93) begin
                send_packet(1'b0, 1'($urandom), pick_len());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word('{rx_byte: 8'($urandom), packet_first: 1'($urandom)});
                end
            end
        end
        drain_results();
    endtask

    // Message longer than the buffer: writes past the end are flagged
    task automatic test_buffer_overflow();
        send_idle_pct = 37;
        stall_pct     = 37;
        send_packet(1'b1, 1'b0, 63);
        repeat (4) send_packet(1'b0, 1'b0, 63);
        send_packet(1'b0, 1'b1, $urandom_range(1, 20));
        send_packet(1'b1, 1'b1, 3);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps going
    task automatic test_output_holdoff();
        int stop;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 150;
        stop          = n_sent + 40;
        while (n_sent < stop)
            send_packet(1'b1, 1'b1, $urandom_range(1, 6));
        drain_results();
    endtask

    // Receiver stall: random, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            n_errors++;
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                exp_w = pending_results.pop_front();
                check_field("store_valid", exp_w.store_valid, o_data.store_valid);
                check_field("store_addr", exp_w.store_addr, o_data.store_addr);
                check_field("store_data", exp_w.store_data, o_data.store_data);
                check_field("message_done", exp_w.message_done, o_data.message_done);
                check_field("message_length", exp_w.message_length,
                            o_data.message_length);
                check_field("partial_dropped", exp_w.partial_dropped,
                            o_data.partial_dropped);
                check_field("fragment_rejected", exp_w.fragment_rejected,
                            o_data.fragment_rejected);
                check_field("overflow", exp_w.overflow, o_data.overflow);
                n_checked++;
                n_done     += exp_w.message_done;
                n_dropped  += exp_w.partial_dropped;
                n_rejected += exp_w.fragment_rejected;
                n_overflow += exp_w.overflow;
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_valid && o_stall)
            n_in_stalls++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_fragment_reassembler: errors");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(170, 0, 0);
        test_random_traffic(170, 53, 0);
        test_random_traffic(170, 0, 53);
        test_random_traffic(170, 37, 37);
        test_buffer_overflow();
        test_output_holdoff();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d input words, %0d results checked: %0d messages, %0d drops,",
                 n_sent, n_checked, n_done, n_dropped);
        $display("  %0d rejected fragments, %0d overflow bytes, %0d input stall cycles",
                 n_rejected, n_overflow, n_in_stalls);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("tb_fragment_reassembler: clean");
        end else begin
            $display("tb_fragment_reassembler: errors");
        end
        $finish;
    end

endmodule
